>>> rtl/vip_front_bounded_queue_top_defines.svh
// Assertion macros used by the checker file of the queue.
`ifndef VIP_FRONT_BOUNDED_QUEUE_TOP_DEFINES_SVH
`define VIP_FRONT_BOUNDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define VFBQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define VFBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/vfbq_pkg.sv
package vfbq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int ID_W = 31;
	localparam int OCC_W = 7;
	localparam int STATUS_W = 2;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_POP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED  = 2'd0,
		ST_FULL   = 2'd1,
		ST_POPPED = 2'd2,
		ST_EMPTY  = 2'd3
	} vfbq_status_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [ID_W-1:0]  wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} vfbq_ram_req_t;

endpackage

>>> rtl/vip_front_bounded_queue_top.sv
// An accepted item passes valid_s1, then the output register, before rsp_valid rises.
// Throughput: one item per cycle while req_stall is low. An add with room writes one
// entry, a pop with an entry reads one; the head and count update in the same cycle.
// Reset (arst_n low) clears the head pointer, entry count and stage valids.
// The entry store is not cleared; only written entries are ever read.
module vip_front_bounded_queue_top import vfbq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                opcode,
	input  logic [ID_W-1:0]     client_id,
	input  logic                is_priority,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     popped_id,
	output logic [OCC_W-1:0]    occupancy
);

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	logic             valid_s1;
	vfbq_status_t     status_s1;
	logic [OCC_W-1:0] occ_s1;

	logic             rsp_valid_q;
	vfbq_status_t     status_q;
	logic [ID_W-1:0]  popped_q;
	logic [OCC_W-1:0] occ_q;

	logic             accept;
	logic             out_free;
	logic             s1_move;
	logic             full;
	logic             empty;
	logic [PTR_W-1:0] head_dec;
	logic [PTR_W-1:0] head_inc;
	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] head_d;
	logic [CNT_W-1:0] count_d;
	vfbq_status_t     status_d;
	logic [31:0]      count_ext;
	vfbq_ram_req_t    ram_req;
	logic [ID_W-1:0]  ram_rdata;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign s1_move   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign accept    = req_valid && !req_stall;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		head_dec = (head_q == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_q - 1'b1;
		head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		// Head plus count stays below twice the depth, so one subtract wraps it.
		tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
			tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
		end else begin
			tail = PTR_W'(tail_sum);
		end
	end

	always_comb begin
		head_d        = head_q;
		count_d       = count_q;
		status_d      = ST_ADDED;
		ram_req       = '0;
		ram_req.wdata = client_id;
		ram_req.raddr = head_q;
		ram_req.waddr = is_priority ? head_dec : tail;
		if (opcode == OP_ADD) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				status_d   = ST_ADDED;
				ram_req.we = accept;
				count_d    = count_q + 1'b1;
				if (is_priority) begin
					head_d = head_dec;
				end
			end
		end else begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				status_d   = ST_POPPED;
				ram_req.re = accept;
				count_d    = count_q - 1'b1;
				head_d     = head_inc;
			end
		end
		count_ext = 32'(count_d);
	end

	vfbq_store u_store (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
			valid_s1 <= accept || (valid_s1 && !s1_move);
			if (out_free) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			occ_s1    <= count_ext[OCC_W-1:0];
		end
		if (s1_move) begin
			status_q <= status_s1;
			occ_q    <= occ_s1;
			// The store's read register holds the head entry for a pop.
			popped_q <= (status_s1 == ST_POPPED) ? ram_rdata : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign popped_id = popped_q;
	assign occupancy = occ_q;

endmodule

>>> rtl/vfbq_store.sv
module vfbq_store import vfbq_pkg::*; (
	input  logic            clk,
	input  vfbq_ram_req_t   req,
	output logic [ID_W-1:0] rdata
);

	logic [ID_W-1:0] mem [QUEUE_DEPTH];
	logic [ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/vfbq_checker.sv
`include "vip_front_bounded_queue_top_defines.svh"

module vfbq_checker import vfbq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [STATUS_W-1:0] status,
	input logic [ID_W-1:0]     popped_id,
	input logic [OCC_W-1:0]    occupancy
);

	localparam logic [OCC_W-1:0] OCC_AT_FULL = OCC_W'(QUEUE_DEPTH % 128);

	logic req_xfer;
	logic rsp_popped;
	logic rsp_empty;
	logic rsp_full;
	logic rsp_wait;
	logic all_idle;

	assign req_xfer   = req_valid && !req_stall;
	assign rsp_popped = rsp_valid && (status == ST_POPPED);
	assign rsp_empty  = rsp_valid && (status == ST_EMPTY);
	assign rsp_full   = rsp_valid && (status == ST_FULL);
	assign rsp_wait   = rsp_valid && rsp_stall;
	assign all_idle   = !req_xfer && !rsp_valid;

	// Only a pop that found an entry may return a nonzero identifier.
	`VFBQ_ASSERT_NOW(a_id_only_on_pop, rsp_valid && !rsp_popped, popped_id == '0, "popped_id set without a pop")

	`VFBQ_ASSERT_NOW(a_empty_occ, rsp_empty, occupancy == '0, "empty pop with nonzero occupancy")

	`VFBQ_ASSERT_NOW(a_full_occ, rsp_full, occupancy == OCC_AT_FULL, "rejected add below capacity")

	`VFBQ_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable({status, popped_id, occupancy}), "stalled result changed")

	// A result is never produced from an idle input side in the next cycle.
	`VFBQ_ASSERT_NEXT(a_no_result_from_nothing, all_idle && !$past(req_xfer), !rsp_valid, "result without a transfer in")

endmodule

bind vip_front_bounded_queue_top vfbq_checker u_vfbq_checker (.*);
